// File: rtl/core/adsrl_pkg.sv
// Shared types, codes, reset values and arithmetic for the armed dual slew-rate limiter.
package adsrl_pkg;

  localparam int AxisW   = 16;
  localparam int VelW    = 16;
  localparam int CfgW    = 15;
  localparam int CfgIdxW = 3;
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic signed [VelW-1:0]  vel_t;
  typedef logic [CfgW-1:0]         cfg_val_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LINEAR   = 3'd0,
    REG_MAX_ANGULAR  = 3'd1,
    REG_LINEAR_STEP  = 3'd2,
    REG_ANGULAR_STEP = 3'd3,
    REG_ALWAYS_ARMED = 3'd4
  } reg_idx_t;

  localparam cfg_val_t RST_MAX_LINEAR   = 15'd901;
  localparam cfg_val_t RST_MAX_ANGULAR  = 15'd15729;
  localparam cfg_val_t RST_LINEAR_STEP  = 15'd90;
  localparam cfg_val_t RST_ANGULAR_STEP = 15'd1573;

  // round(axis * maxv / 2^15), nearest, ties toward +infinity
  function automatic vel_t scale_axis(axis_t axis, cfg_val_t maxv);
    logic signed [AxisW+CfgW:0] prod;
    logic signed [AxisW+CfgW:0] shifted;
    prod    = axis * $signed({1'b0, maxv}) + (AxisW+CfgW+1)'(16384);
    shifted = prod >>> CfgW;
    return shifted[VelW-1:0];
  endfunction

  // move cur toward tgt by at most step, land exactly when close
  function automatic vel_t slew(vel_t cur, vel_t tgt, cfg_val_t step);
    logic signed [VelW:0] diff;
    logic [VelW:0]        mag;
    logic signed [VelW:0] moved;
    diff  = {tgt[VelW-1], tgt} - {cur[VelW-1], cur};
    mag   = diff[VelW] ? (VelW+1)'(-diff) : diff;
    moved = diff[VelW] ? {cur[VelW-1], cur} - $signed({2'b00, step})
                       : {cur[VelW-1], cur} + $signed({2'b00, step});
    return (mag <= {2'b00, step}) ? tgt : moved[VelW-1:0];
  endfunction

endpackage

// File: rtl/core/armed_dual_slew_rate_limiter.sv
// Top level of the armed dual slew-rate limiter: input register, state update, result register.
//
// Usage:
//   s_* stream carries joystick samples (tuser = 0) and publish ticks (tuser = 1).
//   m_* stream carries velocity commands; tuser marks the zero command sent at disarm.
//   cfg_* channel writes the five registers (index, data); write only while idle.
//   A sample retargets both channels and, unless always-armed, runs the arm button logic;
//   a release while armed disarms, zeroes all state and emits a zero command. A tick,
//   while armed or always-armed, slews each channel by at most its step, emits the new pair.
// Path: m_tvalid is driven by the result register, loaded from the input register
//   (input register, then result register). Throughput: one item per cycle while
//   no result waits on m_tready; the per-item work is one 16x15 multiply per channel,
//   or one subtract, compare and add per channel between the two registers.
// Reset: synchronous; clears armed, targets, current values and both valid flags,
//   restores register defaults. s_tready and cfg_ready are low during reset.
// Stall: a result waiting on m_tready holds; one further item may sit in the
//   input register, then s_tready drops until the result is taken.
module armed_dual_slew_rate_limiter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [adsrl_pkg::InDataW-1:0]      s_tdata,   // linear_axis, angular_axis, arm_pressed
  input  logic                               s_tuser,   // kind
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [adsrl_pkg::OutDataW-1:0]     m_tdata,   // linear_velocity, angular_velocity
  output logic                               m_tuser,   // from_disarm
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adsrl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [adsrl_pkg::CfgW-1:0]         cfg_data
);

  adsrl_pkg::cfg_val_t max_linear, max_angular, linear_step, angular_step;
  logic                arm_bypass;

  logic                in_valid;
  adsrl_pkg::kind_t    in_kind;
  adsrl_pkg::axis_t    in_lin_axis, in_ang_axis;
  logic                in_pressed;

  logic                armed, armed_next;
  adsrl_pkg::vel_t     tgt_lin, tgt_ang, cur_lin, cur_ang;
  adsrl_pkg::vel_t     tgt_lin_next, tgt_ang_next, cur_lin_next, cur_ang_next;
  logic                emit;
  logic                emit_disarm;

  logic                out_valid;
  adsrl_pkg::vel_t     out_lin, out_ang;
  logic                out_disarm;

  logic                advance;

  assign advance   = !out_valid || m_tready;
  assign s_tready  = !rst && (!in_valid || advance);
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear   <= adsrl_pkg::RST_MAX_LINEAR;
      max_angular  <= adsrl_pkg::RST_MAX_ANGULAR;
      linear_step  <= adsrl_pkg::RST_LINEAR_STEP;
      angular_step <= adsrl_pkg::RST_ANGULAR_STEP;
      arm_bypass   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (adsrl_pkg::reg_idx_t'(cfg_index))
        adsrl_pkg::REG_MAX_LINEAR:   max_linear   <= cfg_data;
        adsrl_pkg::REG_MAX_ANGULAR:  max_angular  <= cfg_data;
        adsrl_pkg::REG_LINEAR_STEP:  linear_step  <= cfg_data;
        adsrl_pkg::REG_ANGULAR_STEP: angular_step <= cfg_data;
        adsrl_pkg::REG_ALWAYS_ARMED: arm_bypass   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind     <= adsrl_pkg::kind_t'(s_tuser);
      in_lin_axis <= s_tdata[15:0];
      in_ang_axis <= s_tdata[31:16];
      in_pressed  <= s_tdata[32];
    end
  end

  always_comb begin
    armed_next   = armed;
    tgt_lin_next = tgt_lin;
    tgt_ang_next = tgt_ang;
    cur_lin_next = cur_lin;
    cur_ang_next = cur_ang;
    emit         = 1'b0;
    emit_disarm  = 1'b0;
    case (in_kind)
      adsrl_pkg::KIND_SAMPLE: begin
        tgt_lin_next = adsrl_pkg::scale_axis(in_lin_axis, max_linear);
        tgt_ang_next = adsrl_pkg::scale_axis(in_ang_axis, max_angular);
        if (!arm_bypass) begin
          if (!in_pressed && armed) begin
            armed_next   = 1'b0;
            tgt_lin_next = '0;
            tgt_ang_next = '0;
            cur_lin_next = '0;
            cur_ang_next = '0;
            emit         = 1'b1;
            emit_disarm  = 1'b1;
          end else if (in_pressed && !armed) begin
            armed_next = 1'b1;
          end
        end
      end
      adsrl_pkg::KIND_TICK: begin
        if (armed || arm_bypass) begin
          cur_lin_next = adsrl_pkg::slew(cur_lin, tgt_lin, linear_step);
          cur_ang_next = adsrl_pkg::slew(cur_ang, tgt_ang, angular_step);
          emit         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      tgt_lin <= '0;
      tgt_ang <= '0;
      cur_lin <= '0;
      cur_ang <= '0;
    end else if (in_valid && advance) begin
      armed   <= armed_next;
      tgt_lin <= tgt_lin_next;
      tgt_ang <= tgt_ang_next;
      cur_lin <= cur_lin_next;
      cur_ang <= cur_ang_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && emit) begin
      out_lin    <= cur_lin_next;
      out_ang    <= cur_ang_next;
      out_disarm <= emit_disarm;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_ang, out_lin};
  assign m_tuser  = out_disarm;

endmodule

// File: rtl/core/adsrl_checker.sv
// Port-level checker for the armed dual slew-rate limiter and its bind statement.
module adsrl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [adsrl_pkg::OutDataW-1:0] m_tdata,
  input logic                           m_tuser
);

  property p_hold_stalled;
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
  endproperty
  a_hold_stalled: assert property (p_hold_stalled)
    else $error("stalled result changed or dropped");

  property p_disarm_zero;
    @(posedge clk) disable iff (rst)
      m_tvalid && m_tuser |-> m_tdata == '0;
  endproperty
  a_disarm_zero: assert property (p_disarm_zero)
    else $error("disarm command is not zero");

  property p_result_follows_input;
    @(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2);
  endproperty
  a_result_follows_input: assert property (p_result_follows_input)
    else $error("result without an input transfer two cycles earlier");

  property p_quiet_after_reset;
    @(posedge clk) $past(rst) |-> !m_tvalid;
  endproperty
  a_quiet_after_reset: assert property (p_quiet_after_reset)
    else $error("result valid right after reset");

endmodule

bind armed_dual_slew_rate_limiter adsrl_checker u_adsrl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
